// File: hw/rtl/slbm_pkg.sv
package slbm_pkg;

  typedef enum logic [1:0] {
    CMD_CPU_READ  = 2'd0,
    CMD_CPU_WRITE = 2'd1,
    CMD_PPU_FETCH = 2'd2,
    CMD_UNUSED    = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    SEL_CONTROL = 2'd0,
    SEL_CHR_LOW = 2'd1,
    SEL_CHR_HI  = 2'd2,
    SEL_PRG     = 2'd3
  } reg_sel_e;

  typedef enum logic [1:0] {
    CFG_PRG_ROM_BANKS = 2'd0,
    CFG_CHR_ROM_BANKS = 2'd1,
    CFG_SPARE_2       = 2'd2,
    CFG_SPARE_3       = 2'd3
  } cfg_idx_e;

  localparam int unsigned PRG_OFS_BITS = 14;  // 16KB bank
  localparam int unsigned CHR_OFS_BITS = 12;  // 4KB bank

  localparam logic [4:0] SHIFT_EMPTY    = 5'h10;
  localparam logic [4:0] CONTROL_RESET  = 5'h0C;
  localparam logic [4:0] PRG_MODE3_BITS = 5'h0C;
  localparam logic [4:0] PRG_BANKS_MAX  = 5'd16;
  localparam logic [5:0] CHR_BANKS_MAX  = 6'd32;
  localparam logic [4:0] PRG_BANKS_RST  = 5'd16;
  localparam logic [5:0] CHR_BANKS_RST  = 6'd0;

  typedef struct packed {
    logic [1:0]  command;
    logic [15:0] cpu_address;
    logic [7:0]  write_data;
    logic [12:0] ppu_address;
  } in_beat_t;

  typedef struct packed {
    logic [17:0] prg_offset;
    logic        prg_selected;
    logic        data_is_zero;
    logic [16:0] chr_offset;
    logic        chr_is_ram;
    logic [1:0]  mirroring;
  } out_beat_t;

  typedef struct packed {
    logic [4:0] control;
    logic [4:0] prg_bank;
    logic [4:0] chr_low;
    logic [4:0] chr_high;
  } bank_regs_t;

  typedef struct packed {
    logic [4:0] prg_rom_banks;
    logic [5:0] chr_rom_banks;
  } rom_size_t;

endpackage

// File: hw/rtl/slbm_loader.sv
module slbm_loader import slbm_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       fire_i,
  input  in_beat_t   beat_i,
  output bank_regs_t regs_o,
  output logic [1:0] mirroring_o
);

  logic [4:0] shift_q, shift_d;
  bank_regs_t regs_q, regs_d;
  logic [4:0] shifted;
  reg_sel_e   sel;

  assign shifted = {beat_i.write_data[0], shift_q[4:1]};
  assign sel     = reg_sel_e'(beat_i.cpu_address[14:13]);

  always_comb begin
    shift_d = shift_q;
    regs_d  = regs_q;
    if (fire_i && beat_i.command == CMD_CPU_WRITE && beat_i.cpu_address[15]) begin
      if (beat_i.write_data[7]) begin
        shift_d        = SHIFT_EMPTY;
        regs_d.control = regs_q.control | PRG_MODE3_BITS;
      end else if (shift_q[0]) begin
        shift_d = SHIFT_EMPTY;
        case (sel)
          SEL_CONTROL: regs_d.control  = shifted;
          SEL_CHR_LOW: regs_d.chr_low  = shifted;
          SEL_CHR_HI:  regs_d.chr_high = shifted;
          SEL_PRG:     regs_d.prg_bank = shifted;
          default:     regs_d.control  = shifted;
        endcase
      end else begin
        shift_d = shifted;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shift_q         <= SHIFT_EMPTY;
      regs_q.control  <= CONTROL_RESET;
      regs_q.prg_bank <= '0;
      regs_q.chr_low  <= '0;
      regs_q.chr_high <= '0;
    end else begin
      shift_q <= shift_d;
      regs_q  <= regs_d;
    end
  end

  assign regs_o      = regs_q;
  assign mirroring_o = regs_d.control[1:0];

endmodule

// File: hw/rtl/slbm_translate.sv
module slbm_translate import slbm_pkg::*; (
  input  in_beat_t   beat_i,
  input  bank_regs_t regs_i,
  input  rom_size_t  size_i,
  input  logic [1:0] mirroring_i,
  output out_beat_t  result_o
);

  logic [4:0] prg_banks;
  logic [3:0] prg_last;
  logic [3:0] prg_bank;
  logic       prg_upper;
  logic [5:0] chr_banks;
  logic [4:0] chr_bank;
  logic       chr_upper;

  always_comb begin
    prg_banks = (size_i.prg_rom_banks > PRG_BANKS_MAX) ? PRG_BANKS_MAX : size_i.prg_rom_banks;
    prg_last  = (prg_banks == 5'd0) ? 4'd0 : 4'(prg_banks - 5'd1);
    prg_upper = beat_i.cpu_address[14];
    case (regs_i.control[3:2])
      2'd0, 2'd1: prg_bank = {regs_i.prg_bank[3:1], prg_upper};
      2'd2:       prg_bank = prg_upper ? regs_i.prg_bank[3:0] : 4'd0;
      default:    prg_bank = prg_upper ? prg_last : regs_i.prg_bank[3:0];
    endcase

    chr_banks = (size_i.chr_rom_banks > CHR_BANKS_MAX) ? CHR_BANKS_MAX : size_i.chr_rom_banks;
    chr_upper = beat_i.ppu_address[12];
    if (regs_i.control[4]) begin
      chr_bank = chr_upper ? regs_i.chr_high : regs_i.chr_low;
    end else begin
      chr_bank = {regs_i.chr_low[4:1], chr_upper};
    end
  end

  always_comb begin
    result_o           = '0;
    result_o.mirroring = mirroring_i;
    case (cmd_e'(beat_i.command))
      CMD_CPU_READ: begin
        if (beat_i.cpu_address[15]) begin
          result_o.prg_selected = 1'b1;
          result_o.prg_offset   = {prg_bank, beat_i.cpu_address[PRG_OFS_BITS-1:0]};
          result_o.data_is_zero = ({1'b0, prg_bank} >= prg_banks);
        end else begin
          result_o.data_is_zero = 1'b1;
        end
      end
      CMD_CPU_WRITE: begin
        result_o.data_is_zero = 1'b1;
      end
      CMD_PPU_FETCH: begin
        if (size_i.chr_rom_banks == 6'd0) begin
          result_o.chr_is_ram = 1'b1;
          result_o.chr_offset = {4'd0, beat_i.ppu_address};
        end else begin
          result_o.chr_offset   = {chr_bank, beat_i.ppu_address[CHR_OFS_BITS-1:0]};
          result_o.data_is_zero = ({1'b0, chr_bank} >= chr_banks);
        end
      end
      default: begin
        result_o.data_is_zero = 1'b0;
      end
    endcase
  end

endmodule

// File: hw/rtl/serial_loaded_bank_mapper.sv
// Serially loaded cartridge bank mapper.
// Input channel (in_valid_i/in_ready_o/in_data_i): one bus access per beat,
// a CPU read, a CPU write or a PPU pattern fetch. CPU writes at 0x8000 and up
// feed the five-bit serial loader that sets control, CHR and PRG banks.
// Output channel (out_valid_o/out_ready_i/out_data_o): one result beat per
// access with the PRG or CHR offset, the zero-data flag and mirroring.
// Config channel (cfg_valid_i/cfg_ready_o/cfg_index_i/cfg_data_i): index 0
// is the PRG ROM size, index 1 the CHR ROM size; other indexes are dropped.
// Path: input beat to result beat through the input register, then the
// result register. Throughput: one beat per cycle while out_ready_i is
// high, set by the single translation stage between the two registers.
// Reset: shift register empty, control 0x0C, banks 0, PRG size 16, CHR size
// 0 (CHR RAM); both pipeline stages empty.
// Stall: when out_ready_i is low with a result held, the whole pipeline
// holds; in_ready_o stays high while the input register is empty.
module serial_loaded_bank_mapper import slbm_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  in_beat_t   in_data_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output out_beat_t  out_data_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [1:0] cfg_index_i,
  input  logic [5:0] cfg_data_i
);

  logic       in_valid_q;
  in_beat_t   in_beat_q;
  logic       out_valid_q;
  out_beat_t  out_beat_q;
  rom_size_t  size_q;
  logic       advance;
  logic       fire;
  bank_regs_t regs;
  logic [1:0] mirroring;
  out_beat_t  result;

  assign advance    = !out_valid_q || out_ready_i;
  assign fire       = in_valid_q && advance;
  assign in_ready_o = !in_valid_q || advance;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q.prg_rom_banks <= PRG_BANKS_RST;
      size_q.chr_rom_banks <= CHR_BANKS_RST;
    end else if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_PRG_ROM_BANKS: size_q.prg_rom_banks <= cfg_data_i[4:0];
        CFG_CHR_ROM_BANKS: size_q.chr_rom_banks <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (advance) begin
        out_valid_q <= in_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_beat_q <= in_data_i;
    end
    if (fire) begin
      out_beat_q <= result;
    end
  end

  slbm_loader u_loader (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (fire),
    .beat_i      (in_beat_q),
    .regs_o      (regs),
    .mirroring_o (mirroring)
  );

  slbm_translate u_translate (
    .beat_i      (in_beat_q),
    .regs_i      (regs),
    .size_i      (size_q),
    .mirroring_i (mirroring),
    .result_o    (result)
  );

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_beat_q;

endmodule
